// ===== src/brpu_pkg.sv =====
`timescale 1ns / 1ps
package brpu_pkg;

  // Plane and destination limits
  localparam int MAX_SRC_W = 128;
  localparam int MAX_SRC_H = 128;
  localparam int MAX_DST   = 4096;

  // Fixed field widths of the ports
  localparam int SAMPLE_W     = 16;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int SRC_CFG_W    = 8;
  localparam int DST_CFG_W    = 13;
  localparam int LOAD_COORD_W = 7;
  localparam int OUT_COORD_W  = 12;

  // Derived widths
  localparam int FRAC_W      = 16;
  localparam int COL_W       = $clog2(MAX_SRC_W);
  localparam int ROW_W       = $clog2(MAX_SRC_H);
  localparam int SRC_IDX_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int STEP_W      = SRC_IDX_W + FRAC_W;
  localparam int DEN_W       = $clog2(MAX_DST);
  localparam int CNT_W       = $clog2(STEP_W + 1);
  localparam int SW_W        = $clog2(MAX_SRC_W + 1);
  localparam int SH_W        = $clog2(MAX_SRC_H + 1);
  localparam int DSZ_W       = $clog2(MAX_DST + 1);
  localparam int PROD_W      = OUT_COORD_W + STEP_W;
  localparam int IPART_W     = PROD_W - FRAC_W;
  localparam int PLANE_DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int ADDR_W      = $clog2(PLANE_DEPTH);

  // Size register reset values, held inside the legal range
  localparam int SW_RST = (MAX_SRC_W < 128) ? MAX_SRC_W : 128;
  localparam int SH_RST = (MAX_SRC_H < 128) ? MAX_SRC_H : 128;
  localparam int DW_RST = (MAX_DST < 512) ? MAX_DST : 512;
  localparam int DH_RST = (MAX_DST < 512) ? MAX_DST : 512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_MUL,
    ST_SEL,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_H1,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    CNR_00,
    CNR_01,
    CNR_10,
    CNR_11
  } corner_e;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_P00,
    CAP_P01,
    CAP_P10
  } cap_e;

  typedef struct packed {
    logic    accept;
    logic    div_start;
    logic    div_is_y;
    logic    step_x_we;
    logic    step_y_we;
    logic    prod_we;
    logic    coord_we;
    logic    mem_re;
    corner_e corner;
    cap_e    cap;
    logic    h0_we;
    logic    h1_we;
    logic    out_we;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic err;
    logic out_full;
  } ctrl_stat_t;

endpackage

// ===== src/brpu_div.sv =====
`timescale 1ns / 1ps
module brpu_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [brpu_pkg::STEP_W-1:0] num_i,
  input  logic [brpu_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [brpu_pkg::STEP_W-1:0] quot_o
);
  import brpu_pkg::*;

  logic [STEP_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    trial;
  logic              ge;

  // Restoring division, one quotient bit per cycle; numerator bits shift
  // out of quo_q while quotient bits shift in.
  always_comb begin
    trial  = {rem_q, quo_q[STEP_W-1]};
    ge     = (trial >= {1'b0, den_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CNT_W'(STEP_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d  = {quo_q[STEP_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== src/brpu_dpath.sv =====
`timescale 1ns / 1ps
module brpu_dpath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  brpu_pkg::ctrl_cmd_t                     cmd_i,
  output brpu_pkg::ctrl_stat_t                    stat_o,
  input  logic                                    cfg_we_i,
  input  logic [brpu_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [brpu_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  logic                                    func_i,
  input  logic [brpu_pkg::LOAD_COORD_W-1:0]       load_col_i,
  input  logic [brpu_pkg::LOAD_COORD_W-1:0]       load_row_i,
  input  logic signed [brpu_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [brpu_pkg::OUT_COORD_W-1:0]        out_col_i,
  input  logic [brpu_pkg::OUT_COORD_W-1:0]        out_row_i,
  input  logic                                    out_ready_i,
  output logic                                    out_valid_o,
  output logic signed [brpu_pkg::SAMPLE_W-1:0]    value_o,
  output logic                                    range_error_o
);
  import brpu_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int SUM_W  = DIFF_W + 1;

  // Effective sizes
  logic [SW_W-1:0]  sw_q, sw_d;
  logic [SH_W-1:0]  sh_q, sh_d;
  logic [DSZ_W-1:0] dw_q, dw_d;
  logic [DSZ_W-1:0] dh_q, dh_d;

  // Steps and divider
  logic [STEP_W-1:0] step_x_q, step_y_q;
  logic [STEP_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;

  // Query path
  logic [OUT_COORD_W-1:0] oc_q, or_q;
  logic [PROD_W-1:0]      sx_q, sy_q;
  logic                   err, err_q;
  logic [IPART_W-1:0]     ix, iy, ix_p1, iy_p1;
  logic                   copy_x;
  logic [COL_W-1:0]       col0_q, col1_q, col0_d, col1_d, last_col;
  logic [ROW_W-1:0]       row0_q, row1_q, row0_d, row1_d, last_row;
  logic [FRAC_W-1:0]      fx_q, fy_q, fx_d, fy_d;

  // Plane memory
  logic [SAMPLE_W-1:0]        plane_mem [PLANE_DEPTH];
  logic                       mem_we;
  logic [ADDR_W-1:0]          waddr, raddr;
  logic [COL_W-1:0]           rd_col;
  logic [ROW_W-1:0]           rd_row;
  logic signed [SAMPLE_W-1:0] mem_q;
  logic signed [SAMPLE_W-1:0] p00_q, p01_q, p10_q, h0_q, h1_q;

  // Interpolation unit
  logic signed [SAMPLE_W-1:0]      lp_a, lp_b, lp_res;
  logic [FRAC_W-1:0]               lp_f;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [DIFF_W+FRAC_W:0]   prod;
  logic signed [SUM_W-1:0]         sum;

  // Output word
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] value_q;
  logic                       range_err_q;

  // Size registers: zero acts as one, large values saturate
  always_comb begin
    sw_d = sw_q;
    sh_d = sh_q;
    dw_d = dw_q;
    dh_d = dh_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SRC_WIDTH: begin
          priority if (cfg_wdata_i[SRC_CFG_W-1:0] == '0) sw_d = SW_W'(1);
          else if (32'(cfg_wdata_i[SRC_CFG_W-1:0]) > 32'(MAX_SRC_W)) sw_d = SW_W'(MAX_SRC_W);
          else sw_d = SW_W'(cfg_wdata_i[SRC_CFG_W-1:0]);
        end
        REG_SRC_HEIGHT: begin
          priority if (cfg_wdata_i[SRC_CFG_W-1:0] == '0) sh_d = SH_W'(1);
          else if (32'(cfg_wdata_i[SRC_CFG_W-1:0]) > 32'(MAX_SRC_H)) sh_d = SH_W'(MAX_SRC_H);
          else sh_d = SH_W'(cfg_wdata_i[SRC_CFG_W-1:0]);
        end
        REG_DST_WIDTH: begin
          priority if (cfg_wdata_i[DST_CFG_W-1:0] == '0) dw_d = DSZ_W'(1);
          else if (32'(cfg_wdata_i[DST_CFG_W-1:0]) > 32'(MAX_DST)) dw_d = DSZ_W'(MAX_DST);
          else dw_d = DSZ_W'(cfg_wdata_i[DST_CFG_W-1:0]);
        end
        REG_DST_HEIGHT: begin
          priority if (cfg_wdata_i[DST_CFG_W-1:0] == '0) dh_d = DSZ_W'(1);
          else if (32'(cfg_wdata_i[DST_CFG_W-1:0]) > 32'(MAX_DST)) dh_d = DSZ_W'(MAX_DST);
          else dh_d = DSZ_W'(cfg_wdata_i[DST_CFG_W-1:0]);
        end
      endcase
    end
  end

  // Step = ((src - 1) << 16) / (dst - 1)
  assign div_num = cmd_i.div_is_y
                 ? {SRC_IDX_W'(sh_q - SH_W'(1)), {FRAC_W{1'b0}}}
                 : {SRC_IDX_W'(sw_q - SW_W'(1)), {FRAC_W{1'b0}}};
  assign div_den = cmd_i.div_is_y ? DEN_W'(dh_q - DSZ_W'(1)) : DEN_W'(dw_q - DSZ_W'(1));

  brpu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign err = (32'(oc_q) >= 32'(dw_q)) || (32'(or_q) >= 32'(dh_q));

  // Pick the two source columns and rows and the fractions
  always_comb begin
    ix       = sx_q[PROD_W-1:FRAC_W];
    iy       = sy_q[PROD_W-1:FRAC_W];
    ix_p1    = ix + IPART_W'(1);
    iy_p1    = iy + IPART_W'(1);
    last_col = COL_W'(sw_q - SW_W'(1));
    last_row = ROW_W'(sh_q - SH_W'(1));
    copy_x   = (32'(oc_q) + 32'd1 == 32'(dw_q)) || (sw_q == SW_W'(1))
            || (32'(ix) + 32'd1 >= 32'(sw_q));
    col0_d   = copy_x ? last_col : ix[COL_W-1:0];
    col1_d   = copy_x ? last_col : ix_p1[COL_W-1:0];
    fx_d     = copy_x ? '0 : sx_q[FRAC_W-1:0];
    priority if (dh_q == DSZ_W'(1)) begin
      row0_d = '0;
      row1_d = '0;
      fy_d   = '0;
    end else if ((32'(or_q) + 32'd1 == 32'(dh_q)) || (sh_q == SH_W'(1))
                 || (32'(iy) + 32'd1 >= 32'(sh_q))) begin
      row0_d = last_row;
      row1_d = last_row;
      fy_d   = '0;
    end else begin
      row0_d = iy[ROW_W-1:0];
      row1_d = iy_p1[ROW_W-1:0];
      fy_d   = sy_q[FRAC_W-1:0];
    end
  end

  // Memory addressing
  always_comb begin
    unique case (cmd_i.corner)
      CNR_00: begin rd_row = row0_q; rd_col = col0_q; end
      CNR_01: begin rd_row = row0_q; rd_col = col1_q; end
      CNR_10: begin rd_row = row1_q; rd_col = col0_q; end
      CNR_11: begin rd_row = row1_q; rd_col = col1_q; end
    endcase
  end

  assign raddr  = ADDR_W'(rd_row) * ADDR_W'(MAX_SRC_W) + ADDR_W'(rd_col);
  assign waddr  = ADDR_W'(ROW_W'(load_row_i)) * ADDR_W'(MAX_SRC_W)
                + ADDR_W'(COL_W'(load_col_i));
  // Drop loads that fall outside the source size
  assign mem_we = cmd_i.accept && (func_i == FUNC_LOAD)
               && (32'(load_col_i) < 32'(sw_q)) && (32'(load_row_i) < 32'(sh_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      plane_mem[waddr] <= sample_i;
    end
    if (cmd_i.mem_re) begin
      mem_q <= plane_mem[raddr];
    end
  end

  // Shared interpolation: a + floor(f * (b - a) / 2^16)
  always_comb begin
    priority if (cmd_i.h0_we) begin
      lp_a = p00_q;
      lp_b = p01_q;
      lp_f = fx_q;
    end else if (cmd_i.h1_we) begin
      lp_a = p10_q;
      lp_b = mem_q;
      lp_f = fx_q;
    end else begin
      lp_a = h0_q;
      lp_b = h1_q;
      lp_f = fy_q;
    end
    diff   = DIFF_W'(lp_b) - DIFF_W'(lp_a);
    prod   = diff * $signed({1'b0, lp_f});
    sum    = SUM_W'(lp_a) + $signed(prod[DIFF_W+FRAC_W:FRAC_W]);
    lp_res = sum[SAMPLE_W-1:0];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_we) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q        <= SW_W'(SW_RST);
      sh_q        <= SH_W'(SH_RST);
      dw_q        <= DSZ_W'(DW_RST);
      dh_q        <= DSZ_W'(DH_RST);
      out_valid_q <= 1'b0;
    end else begin
      sw_q        <= sw_d;
      sh_q        <= sh_d;
      dw_q        <= dw_d;
      dh_q        <= dh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_x_we) begin
      step_x_q <= (dw_q == DSZ_W'(1)) ? '0 : div_quot;
    end
    if (cmd_i.step_y_we) begin
      step_y_q <= (dh_q == DSZ_W'(1)) ? '0 : div_quot;
    end
    if (cmd_i.accept && (func_i == FUNC_QUERY)) begin
      oc_q <= out_col_i;
      or_q <= out_row_i;
    end
    if (cmd_i.prod_we) begin
      sx_q  <= PROD_W'(oc_q) * PROD_W'(step_x_q);
      sy_q  <= PROD_W'(or_q) * PROD_W'(step_y_q);
      err_q <= err;
    end
    if (cmd_i.coord_we) begin
      col0_q <= col0_d;
      col1_q <= col1_d;
      row0_q <= row0_d;
      row1_q <= row1_d;
      fx_q   <= fx_d;
      fy_q   <= fy_d;
    end
    unique case (cmd_i.cap)
      CAP_NONE: ;
      CAP_P00:  p00_q <= mem_q;
      CAP_P01:  p01_q <= mem_q;
      CAP_P10:  p10_q <= mem_q;
    endcase
    if (cmd_i.h0_we) begin
      h0_q <= lp_res;
    end
    if (cmd_i.h1_we) begin
      h1_q <= lp_res;
    end
    if (cmd_i.out_we) begin
      value_q     <= err_q ? '0 : lp_res;
      range_err_q <= err_q;
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.err      = err;
  assign stat_o.out_full = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign range_error_o = range_err_q;

endmodule

// ===== src/brpu_ctrl.sv =====
`timescale 1ns / 1ps
module brpu_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  func_i,
  input  logic                  cfg_we_i,
  input  brpu_pkg::ctrl_stat_t  stat_i,
  output logic                  in_ready_o,
  output brpu_pkg::ctrl_cmd_t   cmd_o
);
  import brpu_pkg::*;

  state_e state_q, state_d;
  logic   steps_ok_q, steps_ok_d;
  logic   ready;

  assign ready = (state_q == ST_IDLE) && steps_ok_q && !cfg_we_i;

  // Next state
  always_comb begin
    state_d    = state_q;
    steps_ok_d = steps_ok_q;
    unique case (state_q)
      ST_IDLE: begin
        priority if (cfg_we_i) state_d = ST_IDLE;
        else if (!steps_ok_q) state_d = ST_DIVX;
        else if (in_valid_i && (func_i == FUNC_QUERY)) state_d = ST_MUL;
        else state_d = ST_IDLE;
      end
      ST_DIVX: begin
        priority if (cfg_we_i) state_d = ST_IDLE;
        else if (stat_i.div_done) state_d = ST_DIVY;
        else state_d = ST_DIVX;
      end
      ST_DIVY: begin
        priority if (cfg_we_i) state_d = ST_IDLE;
        else if (stat_i.div_done) begin
          state_d    = ST_IDLE;
          steps_ok_d = 1'b1;
        end else begin
          state_d = ST_DIVY;
        end
      end
      ST_MUL:  state_d = stat_i.err ? ST_OUT : ST_SEL;
      ST_SEL:  state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_H1;
      ST_H1:   state_d = ST_OUT;
      ST_OUT:  state_d = stat_i.out_full ? ST_OUT : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      steps_ok_d = 1'b0;
    end
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = ready;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = ready && in_valid_i;
        if (!steps_ok_q && !cfg_we_i) begin
          cmd_o.div_start = 1'b1;
        end
      end
      ST_DIVX: begin
        if (!cfg_we_i && stat_i.div_done) begin
          cmd_o.step_x_we = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_is_y  = 1'b1;
        end
      end
      ST_DIVY: begin
        cmd_o.div_is_y = 1'b1;
        if (!cfg_we_i && stat_i.div_done) begin
          cmd_o.step_y_we = 1'b1;
        end
      end
      ST_MUL: cmd_o.prod_we = 1'b1;
      ST_SEL: cmd_o.coord_we = 1'b1;
      ST_RD0: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.corner = CNR_00;
      end
      ST_RD1: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.corner = CNR_01;
        cmd_o.cap    = CAP_P00;
      end
      ST_RD2: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.corner = CNR_10;
        cmd_o.cap    = CAP_P01;
      end
      ST_RD3: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.corner = CNR_11;
        cmd_o.cap    = CAP_P10;
        cmd_o.h0_we  = 1'b1;
      end
      ST_H1:  cmd_o.h1_we = 1'b1;
      ST_OUT: cmd_o.out_we = !stat_i.out_full;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      steps_ok_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      steps_ok_q <= steps_ok_d;
    end
  end

endmodule

// ===== src/bilinear_plane_resize_unit.sv =====
`timescale 1ns / 1ps
// Loads leave the block idle and are taken back to back. A query passes through multiply,
// select, four single-port reads of the plane memory and the shared interpolation unit
// (an out-of-range query goes from multiply straight to output); no word is taken until
// it leaves the output state. After reset and after any size register write, both Q7.16
// steps are recomputed by a bit-serial divider while no word is accepted; writes are
// still taken. Reset is asynchronous, active low; plane contents are undefined until loaded.
module bilinear_plane_resize_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [brpu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [brpu_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Input words: load a sample or query a pixel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [brpu_pkg::LOAD_COORD_W-1:0]    load_col_i,
  input  logic [brpu_pkg::LOAD_COORD_W-1:0]    load_row_i,
  input  logic signed [brpu_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [brpu_pkg::OUT_COORD_W-1:0]     out_col_i,
  input  logic [brpu_pkg::OUT_COORD_W-1:0]     out_row_i,
  // Result words
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [brpu_pkg::SAMPLE_W-1:0] value_o,
  output logic                                 range_error_o
);
  import brpu_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequencer: step recompute, then per query multiply, select, four reads,
  // two horizontal and one vertical interpolation; an out-of-range query skips to the output.
  brpu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .func_i    (func_i),
    .cfg_we_i  (cfg_we_i),
    .stat_i    (stat),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  // Size registers, divider, plane memory, interpolation and the output register
  // that lets the next word in while a result waits.
  brpu_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (func_i),
    .load_col_i   (load_col_i),
    .load_row_i   (load_row_i),
    .sample_i     (sample_i),
    .out_col_i    (out_col_i),
    .out_row_i    (out_row_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .value_o      (value_o),
    .range_error_o(range_error_o)
  );

  // A size write invalidates the steps, so nothing is taken the cycle after.
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input taken right after a size register write");

  // Never overwrite a result word that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_we |-> !(out_valid_o && !out_ready_i))
    else $error("result word overwritten before it was taken");

  // Out-of-range queries report zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (value_o == '0))
    else $error("range error word carries a nonzero value");

  // A query never finishes in the cycle after it is accepted.
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && (func_i == FUNC_QUERY)) |=> !cmd.out_we)
    else $error("query result written too early");

endmodule

// ===== bench/brpu_resize_checker.sv =====
`timescale 1ns / 1ps
module brpu_resize_checker
  import brpu_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        func_i,
  input  logic [LOAD_COORD_W-1:0]     load_col_i,
  input  logic [LOAD_COORD_W-1:0]     load_row_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  input  logic [OUT_COORD_W-1:0]      out_col_i,
  input  logic [OUT_COORD_W-1:0]      out_row_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [SAMPLE_W-1:0]  value_i,
  input  logic                        range_error_i,
  output int                          mismatch_count_o,
  output int                          pending_o
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       range_error;
  } pixel_t;

  pixel_t                     expected_pixels[$];
  pixel_t                     oldest_px;
  logic signed [SAMPLE_W-1:0] plane_mem [PLANE_DEPTH];
  logic [SRC_CFG_W-1:0]       src_w_q, src_h_q;
  logic [DST_CFG_W-1:0]       dst_w_q, dst_h_q;
  int                         mismatches;

  function automatic int unsigned fit_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned plane_index(int unsigned col, int unsigned row);
    return row * MAX_SRC_W + col;
  endfunction

  function automatic int plane_rd(int unsigned col, int unsigned row);
    return int'(plane_mem[plane_index(col, row)]);
  endfunction

  // Q7.16 source step per destination step, truncated
  function automatic u64_t q16_step(int unsigned src, int unsigned dst);
    u64_t num;
    if (dst <= 1) return 0;
    num = src - 1;
    num = num << 16;
    return num / (dst - 1);
  endfunction

  // a + floor(frac * (b - a) / 2^16)
  function automatic int blend(int a, int b, int unsigned frac);
    longint d;
    longint f;
    d = longint'(b) - longint'(a);
    f = frac;
    return int'(longint'(a) + ((d * f) >>> 16));
  endfunction

  // Horizontal pass along one source row
  function automatic int row_blend(int unsigned col, int unsigned srow, int unsigned sw,
                                   int unsigned dw);
    u64_t        pos;
    int unsigned ix, fx;
    if (col == dw - 1 || sw == 1) return plane_rd(sw - 1, srow);
    pos = u64_t'(col) * q16_step(sw, dw);
    ix = 32'(pos >> 16);
    fx = 32'(pos & 64'hFFFF);
    if (ix + 1 >= sw) return plane_rd(sw - 1, srow);
    return blend(plane_rd(ix, srow), plane_rd(ix + 1, srow), fx);
  endfunction

  function automatic pixel_t resize_pixel(int unsigned oc, int unsigned orow);
    int unsigned sw, sh, dw, dh, iy, fy;
    u64_t        pos;
    int          v;
    pixel_t      px;
    sw = fit_size(src_w_q, MAX_SRC_W);
    sh = fit_size(src_h_q, MAX_SRC_H);
    dw = fit_size(dst_w_q, MAX_DST);
    dh = fit_size(dst_h_q, MAX_DST);
    if (oc >= dw || orow >= dh) begin
      px.value = '0;
      px.range_error = 1'b1;
      return px;
    end
    if (dh == 1) begin
      v = row_blend(oc, 0, sw, dw);
    end else if (orow == dh - 1 || sh == 1) begin
      v = row_blend(oc, sh - 1, sw, dw);
    end else begin
      pos = u64_t'(orow) * q16_step(sh, dh);
      iy = 32'(pos >> 16);
      fy = 32'(pos & 64'hFFFF);
      if (iy + 1 >= sh) v = row_blend(oc, sh - 1, sw, dw);
      else v = blend(row_blend(oc, iy, sw, dw), row_blend(oc, iy + 1, sw, dw), fy);
    end
    px.value = v[SAMPLE_W-1:0];
    px.range_error = 1'b0;
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q = SRC_CFG_W'(SW_RST);
      src_h_q = SRC_CFG_W'(SH_RST);
      dst_w_q = DST_CFG_W'(DW_RST);
      dst_h_q = DST_CFG_W'(DH_RST);
      expected_pixels.delete();
      mismatches = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SRC_WIDTH:  src_w_q = cfg_wdata_i[SRC_CFG_W-1:0];
          REG_SRC_HEIGHT: src_h_q = cfg_wdata_i[SRC_CFG_W-1:0];
          REG_DST_WIDTH:  dst_w_q = cfg_wdata_i[DST_CFG_W-1:0];
          REG_DST_HEIGHT: dst_h_q = cfg_wdata_i[DST_CFG_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with no query waiting: value %0d range_error %0b",
                 value_i, range_error_i);
          mismatches++;
        end else begin
          oldest_px = expected_pixels.pop_front();
          if (value_i !== oldest_px.value) begin
            $error("value: expected %0d, got %0d", oldest_px.value, value_i);
            mismatches++;
          end
          if (range_error_i !== oldest_px.range_error) begin
            $error("range_error: expected %0b, got %0b", oldest_px.range_error,
                   range_error_i);
            mismatches++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (func_e'(func_i) == FUNC_LOAD) begin
          // drop loads outside the configured source plane
          if (load_col_i < fit_size(src_w_q, MAX_SRC_W) &&
              load_row_i < fit_size(src_h_q, MAX_SRC_H))
            plane_mem[plane_index(load_col_i, load_row_i)] = sample_i;
        end else begin
          expected_pixels.push_back(resize_pixel(out_col_i, out_row_i));
        end
      end

      pending_o <= expected_pixels.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== bench/tb_bilinear_plane_resize_unit.sv =====
`timescale 1ns / 1ps
module tb_bilinear_plane_resize_unit;
  import brpu_pkg::*;

  // Cycles to let pass once nothing is expected
  localparam int DRAIN_CYCLES = 16;
  // Long receiver hold-off, long enough to back the block up into its input
  localparam int LONG_HOLD    = 250;
  localparam int HOLD_AFTER   = 30;
  localparam int RAND_PHASES  = 12;
  localparam int RAND_ITEMS   = 16;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i   = '0;
  logic [CFG_W-1:0]            cfg_wdata_i = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic                        func_i      = 1'b0;
  logic [LOAD_COORD_W-1:0]     load_col_i  = '0;
  logic [LOAD_COORD_W-1:0]     load_row_i  = '0;
  logic signed [SAMPLE_W-1:0]  sample_i    = '0;
  logic [OUT_COORD_W-1:0]      out_col_i   = '0;
  logic [OUT_COORD_W-1:0]      out_row_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0]  value_o;
  logic                        range_error_o;

  int                          mismatch_count;
  int                          pending_pixels;

  // Effective plane and destination sizes, used to aim the stimulus
  int unsigned                 eff_sw, eff_sh, eff_dw, eff_dh;
  // Words left in the current sender burst
  int                          burst_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bilinear_plane_resize_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .load_col_i    (load_col_i),
    .load_row_i    (load_row_i),
    .sample_i      (sample_i),
    .out_col_i     (out_col_i),
    .out_row_i     (out_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .range_error_o (range_error_o)
  );

  // The checker watches both channels and the register port, predicts every query
  // and compares results in order.
  brpu_resize_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .func_i           (func_i),
    .load_col_i       (load_col_i),
    .load_row_i       (load_row_i),
    .sample_i         (sample_i),
    .out_col_i        (out_col_i),
    .out_row_i        (out_row_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_i          (value_o),
    .range_error_i    (range_error_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_pixels)
  );

  function automatic int unsigned fit_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Bias sample values toward the Q8.8 extremes and zero
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // In-range destination coordinate, often on an edge
  function automatic int unsigned pick_coord(int unsigned size);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return size - 1;
      2:       return (size >= 2) ? size - 2 : 0;
      default: return $urandom_range(0, size - 1);
    endcase
  endfunction

  // Offer one word and hold it until accepted, then maybe open a gap.
  // Called at a rising edge; returns at the edge of acceptance or after the gap.
  task automatic send_word(func_e fn, int unsigned lc, int unsigned lr,
                           logic [SAMPLE_W-1:0] smp, int unsigned oc, int unsigned orow);
    int unsigned gap;
    in_valid_i <= 1'b1;
    func_i     <= fn;
    load_col_i <= lc[LOAD_COORD_W-1:0];
    load_row_i <= lr[LOAD_COORD_W-1:0];
    sample_i   <= smp;
    out_col_i  <= oc[OUT_COORD_W-1:0];
    out_row_i  <= orow[OUT_COORD_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left == 0) begin
      // new burst: sometimes a long one, sometimes straight on without a gap
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                               : $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Unused fields of a word carry random values so their bits toggle too
  task automatic load_sample(int unsigned col, int unsigned row, logic [SAMPLE_W-1:0] smp);
    send_word(FUNC_LOAD, col, row, smp, $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic query_pixel(int unsigned col, int unsigned row);
    send_word(FUNC_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
              SAMPLE_W'($urandom), col, row);
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four size registers back to back; call only while idle
  task automatic set_sizes(int unsigned sw, int unsigned sh,
                           int unsigned dw, int unsigned dh);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SRC_WIDTH;
    cfg_wdata_i <= CFG_W'(sw);
    @(posedge clk_i);
    cfg_idx_i   <= REG_SRC_HEIGHT;
    cfg_wdata_i <= CFG_W'(sh);
    @(posedge clk_i);
    cfg_idx_i   <= REG_DST_WIDTH;
    cfg_wdata_i <= CFG_W'(dw);
    @(posedge clk_i);
    cfg_idx_i   <= REG_DST_HEIGHT;
    cfg_wdata_i <= CFG_W'(dh);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    eff_sw = fit_size(sw[SRC_CFG_W-1:0], MAX_SRC_W);
    eff_sh = fit_size(sh[SRC_CFG_W-1:0], MAX_SRC_H);
    eff_dw = fit_size(dw[DST_CFG_W-1:0], MAX_DST);
    eff_dh = fit_size(dh[DST_CFG_W-1:0], MAX_DST);
  endtask

  // Write every entry of the active plane so no query reads an unwritten one
  task automatic fill_plane();
    for (int unsigned r = 0; r < eff_sh; r++)
      for (int unsigned c = 0; c < eff_sw; c++)
        load_sample(c, r, pick_sample());
  endtask

  // Mix of reloads, stray loads, out-of-range queries and in-range queries
  task automatic random_items(int n);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        load_sample($urandom_range(0, eff_sw - 1), $urandom_range(0, eff_sh - 1),
                    pick_sample());
      end else if (pick < 27) begin
        // stray coordinates: dropped when outside the plane, a reload when inside
        load_sample($urandom_range(0, 127), $urandom_range(0, 127), pick_sample());
      end else if (pick < 37 && (eff_dw < MAX_DST || eff_dh < MAX_DST)) begin
        if (eff_dw < MAX_DST && ($urandom_range(0, 1) == 0 || eff_dh == MAX_DST))
          query_pixel($urandom_range(eff_dw, 4095), $urandom_range(0, 4095));
        else
          query_pixel($urandom_range(0, 4095), $urandom_range(eff_dh, 4095));
      end else begin
        query_pixel(pick_coord(eff_dw), pick_coord(eff_dh));
      end
    end
  endtask

  // Receiver: segments of always-ready, random ready and short stalls, plus
  // one long hold-off after a number of results so the block backs up.
  initial begin : result_sink
    int mode;
    int seg;
    int results_taken;
    bit long_hold_done;
    results_taken = 0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg = (mode == 3) ? $urandom_range(1, 6) : $urandom_range(1, 40);
      repeat (seg) begin
        @(posedge clk_i);
        if (out_valid_o && out_ready_i) results_taken++;
        if (!long_hold_done && results_taken >= HOLD_AFTER) begin
          long_hold_done = 1'b1;
          out_ready_i <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end else begin
          case (mode)
            0, 1:    out_ready_i <= 1'b1;
            2:       out_ready_i <= 1'($urandom_range(0, 1));
            default: out_ready_i <= 1'b0;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2x2 source of opposite extremes onto 3x3: midpoints, last row and column
    set_sizes(2, 2, 3, 3);
    load_sample(0, 0, 16'h8000);
    load_sample(1, 0, 16'h7FFF);
    load_sample(0, 1, 16'h7FFF);
    load_sample(1, 1, 16'h8000);
    load_sample(127, 127, 16'h1234);  // outside the plane, must be dropped
    query_pixel(0, 0);
    query_pixel(1, 1);
    query_pixel(2, 2);
    query_pixel(1, 2);
    query_pixel(2, 1);
    query_pixel(3, 0);                // column out of range
    query_pixel(0, 3);                // row out of range
    query_pixel(4095, 4095);
    drain_results();

    // one-column, one-row source onto a single destination pixel
    set_sizes(1, 1, 1, 1);
    query_pixel(0, 0);
    query_pixel(1, 0);
    query_pixel(0, 1);
    drain_results();

    // zero sizes act as one, oversized destination saturates
    set_sizes(0, 0, 8191, 8191);
    query_pixel(4095, 4095);
    query_pixel(0, 0);
    query_pixel(2048, 17);
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_sizes(128, 1, $urandom_range(2, 300), $urandom_range(1, 20));
        1: set_sizes(1, 128, $urandom_range(1, 20), $urandom_range(2, 300));
        2: set_sizes(255, 1, 4096, 1);
        // upper data bits beyond each register's width are dropped
        3: set_sizes(13'h105, 13'h1003, 13'h1FFF, 0);
        4: set_sizes(2, 2, 4096, 4096);
        5: set_sizes(200, 0, 5000, 1);
        default: set_sizes($urandom_range(1, 8), $urandom_range(1, 8),
                           $urandom_range(1, 48), $urandom_range(1, 48));
      endcase
      fill_plane();
      random_items(RAND_ITEMS);
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/brpu_pkg.sv
src/brpu_div.sv
src/brpu_dpath.sv
src/brpu_ctrl.sv
src/bilinear_plane_resize_unit.sv
bench/brpu_resize_checker.sv
bench/tb_bilinear_plane_resize_unit.sv
